### rtl/shtc_pkg.sv
// Package for the shared-hit track cleaner: FSM state type, command and status structs.
// No dependencies.
package shtc_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PICK_I,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load_en;
        logic clear_set;
        logic start_i;
        logic next_i;
        logic scan_step;
        logic start_decide;
        logic decide_step;
        logic start_emit;
        logic emit_step;
    } t_cmd;

    typedef struct packed {
        logic set_done;
        logic i_done;
        logic i_valid;
        logic scan_done;
        logic decide_done;
        logic emit_last;
    } t_status;

endpackage

### rtl/shtc_if.sv
// Valid/ready channel interface with source and sink modports.
// No dependencies.
interface shtc_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/shtc_ctrl.sv
// Controller FSM for the shared-hit track cleaner.
// Depends on shtc_pkg.
module shtc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic             i_in_last,
    input  logic             i_out_fire,
    input  shtc_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output shtc_pkg::t_cmd   o_cmd
);
    import shtc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_LOAD;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:   if (i_in_fire && i_in_last) n_state = ST_PICK_I;
            ST_PICK_I: begin
                if (i_status.i_done) n_state = i_status.set_done ? ST_LOAD : ST_EMIT;
                else if (i_status.i_valid) n_state = ST_SCAN;
            end
            ST_SCAN:   if (i_status.scan_done) n_state = ST_DECIDE;
            ST_DECIDE: if (i_status.decide_done) n_state = ST_PICK_I;
            ST_EMIT:   if (i_out_fire && i_status.emit_last) n_state = ST_LOAD;
            default:   n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load_en = i_in_fire;
                o_cmd.start_i = i_in_fire && i_in_last;
            end
            ST_PICK_I: begin
                if (i_status.i_done) begin
                    o_cmd.start_emit = 1'b1;
                    o_cmd.clear_set = i_status.set_done;
                end else if (!i_status.i_valid) o_cmd.next_i = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.start_decide = i_status.scan_done;
            end
            ST_DECIDE: begin
                o_cmd.decide_step = 1'b1;
                o_cmd.next_i = i_status.decide_done;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.emit_step = i_out_fire;
                o_cmd.clear_set = i_out_fire && i_status.emit_last;
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("input and output open together");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && !i_status.scan_done) |=> r_state == ST_SCAN)
        else $error("scan left early");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start_i) |=> r_state == ST_PICK_I) else $error("no cleaning after set end");
endmodule

### rtl/shtc_dp.sv
// Datapath: hit memory, per-track attributes, pair scan counters and result fields.
// Depends on shtc_pkg.
module shtc_dp #(
    parameter int MAX_TRACKS = 16,
    parameter int MAX_HITS_PER_TRACK = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shtc_pkg::t_cmd    i_cmd,
    input  logic [31:0]       i_key,
    input  logic              i_hit_valid,
    input  logic [5:0]        i_found,
    input  logic [23:0]       i_chi,
    input  logic              i_trk_valid,
    input  logic              i_last_hit,
    input  logic              i_last_set,
    output shtc_pkg::t_status o_status,
    output logic [3:0]        o_track_number,
    output logic              o_track_kept,
    output logic              o_load_overflow,
    output logic              o_last_result
);
    import shtc_pkg::*;

    localparam int TW = $clog2(MAX_TRACKS);
    localparam int HW = (MAX_HITS_PER_TRACK > 1) ? $clog2(MAX_HITS_PER_TRACK) : 1;
    localparam int SLOTS = MAX_TRACKS * MAX_HITS_PER_TRACK;
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(MAX_HITS_PER_TRACK * MAX_HITS_PER_TRACK + 1) + 1;

    // hit memory: key plus valid, single write port, registered read
    logic [KEY_WIDTH:0] r_mem [SLOTS];
    logic [KEY_WIDTH:0] r_rd;

    logic [HW:0]   r_hits  [MAX_TRACKS];
    logic [5:0]    r_found [MAX_TRACKS];
    logic [23:0]   r_chi   [MAX_TRACKS];
    logic [MAX_TRACKS-1:0] r_tv;
    logic [CW-1:0] r_cnt   [MAX_TRACKS];
    logic [TW:0]   r_total;
    logic          r_ovf;

    logic [TW:0] r_i, r_j;
    logic [HW:0] r_p, r_q;
    logic [KEY_WIDTH:0] r_a;     // held hit of track i
    logic        r_rd_ok;        // r_rd holds a track-j hit to compare
    logic [TW-1:0] r_cj;         // track of the pending compare
    logic        r_phase;        // 0: fetch hit a, 1: fetch hit b
    logic        r_a_ok;
    logic [TW:0] r_e;

    wire [TW:0] w_t = r_total;
    wire        w_room_t = w_t < (TW+1)'(MAX_TRACKS);
    wire [TW-1:0] w_ti = w_t[TW-1:0];
    wire        w_room_h = r_hits[w_ti] < (HW+1)'(MAX_HITS_PER_TRACK);
    wire [AW-1:0] w_wa = AW'(w_ti) * AW'(MAX_HITS_PER_TRACK) + AW'(r_hits[w_ti]);

    wire [TW-1:0] w_i = r_i[TW-1:0];
    wire [TW-1:0] w_j = r_j[TW-1:0];
    wire          w_j_in = r_j < r_total;
    wire          w_j_use = w_j_in && (r_j != r_i) && r_tv[w_j];
    wire          w_p_end = r_p >= r_hits[w_i];
    wire          w_q_end = !w_j_use || r_q >= r_hits[w_j];
    wire [AW-1:0] w_ra = r_phase ? AW'(w_j) * AW'(MAX_HITS_PER_TRACK) + AW'(r_q)
                                 : AW'(w_i) * AW'(MAX_HITS_PER_TRACK) + AW'(r_p);
    logic w_rd_en;

    always_comb begin
        w_rd_en = 1'b0;
        if (i_cmd.scan_step && !w_p_end) begin
            if (!r_phase) w_rd_en = 1'b1;
            else if (w_j_in && !w_q_end && r_a[KEY_WIDTH]) w_rd_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en && w_room_t && w_room_h)
            r_mem[w_wa] <= {i_hit_valid, KEY_WIDTH'(i_key)};
        if (w_rd_en) r_rd <= r_mem[w_ra];
    end

    // decision inputs
    wire [5:0] w_fi = r_found[w_i];
    wire [5:0] w_fj = r_found[w_j];
    wire [5:0] w_lo = (w_fi < w_fj) ? w_fi : w_fj;
    wire [CW:0] w_c2 = {r_cnt[w_j], 1'b0};
    wire w_fire = (r_cnt[w_j] != '0) && (w_c2 >= (CW+1)'(w_lo));
    wire w_bad_j = (w_fi != w_fj) ? (w_fi > w_fj) : (r_chi[w_j] > r_chi[w_i]);

    wire [TW-1:0] w_e = r_e[TW-1:0];
    assign o_track_number  = 4'(w_e);
    assign o_track_kept    = r_tv[w_e];
    assign o_load_overflow = r_ovf;
    assign o_last_result   = (r_e + 1'b1) == r_total;

    assign o_status.set_done    = r_total == '0;
    assign o_status.i_done      = r_i >= r_total;
    assign o_status.i_valid     = r_tv[w_i];
    assign o_status.scan_done   = w_p_end && !r_rd_ok;
    assign o_status.decide_done = (r_j + 1'b1) >= r_total;
    assign o_status.emit_last   = o_last_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_rd_ok <= 1'b0;
            for (int k = 0; k < MAX_TRACKS; k++) r_hits[k] <= '0;
        end else begin
            r_rd_ok <= 1'b0;
            if (i_cmd.load_en) begin
                if (w_room_t) begin
                    if (w_room_h) r_hits[w_ti] <= r_hits[w_ti] + 1'b1;
                    else          r_ovf <= 1'b1;
                    r_found[w_ti] <= i_found;
                    r_chi[w_ti]   <= i_chi;
                    r_tv[w_ti]    <= i_trk_valid;
                    if (i_last_hit || i_last_set) r_total <= w_t + 1'b1;
                end else r_ovf <= 1'b1;
            end
            if (i_cmd.start_i) r_i <= '0;
            if (i_cmd.next_i) r_i <= r_i + 1'b1;
            if ((i_cmd.start_i || i_cmd.next_i) || i_cmd.start_decide) begin
                r_p <= '0; r_q <= '0; r_j <= '0; r_phase <= 1'b0;
                for (int k = 0; k < MAX_TRACKS; k++)
                    if (!i_cmd.start_decide) r_cnt[k] <= '0;
            end
            if (i_cmd.scan_step) begin
                // count pending compare
                if (r_rd_ok && r_rd[KEY_WIDTH] && r_rd == r_a)
                    r_cnt[r_cj] <= r_cnt[r_cj] + 1'b1;
                if (!w_p_end) begin
                    if (!r_phase) begin
                        r_phase <= 1'b1; r_j <= '0; r_q <= '0;
                    end else begin
                        if (r_a_ok) begin
                            r_a <= r_rd; r_a_ok <= 1'b0;
                        end
                        if (!w_j_in) begin
                            r_phase <= 1'b0; r_p <= r_p + 1'b1;
                        end else if (w_q_end || !(r_a_ok ? r_rd[KEY_WIDTH] : r_a[KEY_WIDTH])) begin
                            r_j <= r_j + 1'b1; r_q <= '0;
                        end else if (!r_a_ok) begin
                            r_q <= r_q + 1'b1; r_rd_ok <= 1'b1; r_cj <= w_j;
                        end
                    end
                end
            end
            if (i_cmd.scan_step && !w_p_end && !r_phase) r_a_ok <= 1'b1;
            if (i_cmd.decide_step) begin
                if (w_j_in && w_fire) begin
                    if (w_bad_j) r_tv[w_j] <= 1'b0;
                    else         r_tv[w_i] <= 1'b0;
                end
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.start_emit) r_e <= '0;
            if (i_cmd.emit_step) r_e <= r_e + 1'b1;
            if (i_cmd.clear_set) begin
                r_total <= '0;
                r_ovf   <= 1'b0;
                for (int k = 0; k < MAX_TRACKS; k++) r_hits[k] <= '0;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= (TW+1)'(MAX_TRACKS)) else $error("track total beyond capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_set |=> r_total == '0 && !r_ovf) else $error("set not cleared");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_ok |-> $past(w_rd_en)) else $error("compare without memory read");
endmodule

### rtl/shared_hit_track_cleaner.sv
// Top level of the shared-hit duplicate track remover; needs shtc_pkg, shtc_if, shtc_ctrl, shtc_dp.
// Loading: one hit transaction per cycle while in the load phase.
// Cleaning: per valid track i, each hit of i is compared with the hits of every other valid track j
// over the single hit-memory read port, followed by one decision step per track.
// Results: one per track, one per cycle when the sink is ready. Synchronous active-low reset
// empties the track set; hit and attribute stores hold undefined data until written.
module shared_hit_track_cleaner #(
    parameter int MAX_TRACKS = 16,
    parameter int MAX_HITS_PER_TRACK = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    shtc_if.sink   i_hit,
    shtc_if.source o_res
);
    import shtc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready, w_out_valid;

    // input payload: key[31:0], hit_valid, found[5:0], chi[23:0], trk_valid, last_hit, last_set
    wire w_in_fire  = i_hit.valid && w_in_ready;
    wire w_out_fire = w_out_valid && o_res.ready;

    assign i_hit.ready = w_in_ready;
    assign o_res.valid = w_out_valid;

    logic [3:0] w_num;
    logic w_kept, w_ovf, w_last;
    // output payload: track_number[6:3], kept[2], overflow[1], last_result[0]
    assign o_res.data = {w_num, w_kept, w_ovf, w_last};

    shtc_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_fire(w_in_fire), .i_in_last(i_hit.data[0]),
        .i_out_fire(w_out_fire), .i_status(w_status),
        .o_in_ready(w_in_ready), .o_out_valid(w_out_valid), .o_cmd(w_cmd)
    );

    shtc_dp #(
        .MAX_TRACKS(MAX_TRACKS), .MAX_HITS_PER_TRACK(MAX_HITS_PER_TRACK),
        .KEY_WIDTH(KEY_WIDTH)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd),
        .i_key(i_hit.data[65:34]), .i_hit_valid(i_hit.data[33]),
        .i_found(i_hit.data[32:27]), .i_chi(i_hit.data[26:3]),
        .i_trk_valid(i_hit.data[2]), .i_last_hit(i_hit.data[1]),
        .i_last_set(i_hit.data[0]), .o_status(w_status),
        .o_track_number(w_num), .o_track_kept(w_kept),
        .o_load_overflow(w_ovf), .o_last_result(w_last)
    );
endmodule
